// ----- rtl/tgr_pkg.sv -----
// Shared types and constants for the touchpad gesture recognizer.
// Holds the config record, controller command/status records and event codes.
// No dependencies.
`default_nettype none

package tgr_pkg;

    localparam int COORD_W   = 16;
    localparam int TIME_W    = 32;
    localparam int ACC_W     = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int PCT_W     = 7;
    localparam int PROD_W    = 23;
    localparam int RECIP_W   = 24;
    localparam int QPROD_W   = PROD_W + RECIP_W;

    localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;
    localparam logic [RECIP_W-1:0] RECIP_100   = 24'd10737419;
    localparam int                 RECIP_SHIFT = 30;

    localparam logic [15:0] RST_RANGE_X      = 16'd4095;
    localparam logic [15:0] RST_RANGE_Y      = 16'd4095;
    localparam logic [15:0] RST_TAP_MOTION   = 16'd64;
    localparam logic [31:0] RST_TAP_DURATION = 32'd180;
    localparam logic [15:0] RST_SCROLL_PITCH = 16'd48;
    localparam logic [6:0]  RST_EDGE_PERCENT = 7'd25;

    localparam logic [2:0] REG_RANGE_X      = 3'd0;
    localparam logic [2:0] REG_RANGE_Y      = 3'd1;
    localparam logic [2:0] REG_TAP_MOTION   = 3'd2;
    localparam logic [2:0] REG_TAP_DURATION = 3'd3;
    localparam logic [2:0] REG_SCROLL_PITCH = 3'd4;
    localparam logic [2:0] REG_EDGE_PERCENT = 3'd5;

    localparam logic [1:0] KIND_SCROLL = 2'd0;
    localparam logic [1:0] KIND_TAP    = 2'd1;
    localparam logic [1:0] KIND_CLICK  = 2'd2;

    localparam logic [1:0] ZONE_MENU = 2'd0;
    localparam logic [1:0] ZONE_PLAY = 2'd1;
    localparam logic [1:0] ZONE_PREV = 2'd2;
    localparam logic [1:0] ZONE_NEXT = 2'd3;

    localparam logic signed [1:0] DELTA_NONE = 2'sd0;
    localparam logic signed [1:0] DELTA_UP   = 2'sd1;
    localparam logic signed [1:0] DELTA_DOWN = -2'sd1;

    localparam logic [1:0] EV_CLICK = 2'd0;
    localparam logic [1:0] EV_UP    = 2'd1;
    localparam logic [1:0] EV_DOWN  = 2'd2;
    localparam logic [1:0] EV_TAP   = 2'd3;

    typedef struct packed {
        logic [15:0] range_x;
        logic [15:0] range_y;
        logic [15:0] tap_motion_limit;
        logic [31:0] tap_duration_limit;
        logic [15:0] scroll_pitch;
        logic [6:0]  edge_percent;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       btn_upd;
        logic       start;
        logic       move;
        logic       end_a;
        logic       end_b;
        logic       emit;
        logic       tick;
        logic       flush;
        logic [1:0] ev_sel;
    } cmd_t;

    typedef struct packed {
        logic s_valid;
        logic s_finger;
        logic touching;
        logic btn_rise;
        logic dy_zero;
        logic tick_up;
        logic tick_dn;
        logic tap_ok;
        logic emit_ok;
        logic pend_valid;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/tgr_if.sv -----
// Valid/ready channels for poll samples and gesture events.
// Depends on nothing but the fixed field widths.
`default_nettype none

interface tgr_sample_if;
    logic        valid;
    logic        ready;
    logic        sample_valid;
    logic        finger_down;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] time_ms;
    logic        button_down;

    modport source (
        output valid, sample_valid, finger_down, pos_x, pos_y, time_ms, button_down,
        input  ready
    );
    modport sink (
        input  valid, sample_valid, finger_down, pos_x, pos_y, time_ms, button_down,
        output ready
    );
endinterface

interface tgr_event_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic signed [1:0] scroll_delta;
    logic [1:0]        tap_zone;
    logic [31:0]       event_time;
    logic              last_event;

    modport source (
        output valid, event_kind, scroll_delta, tap_zone, event_time, last_event,
        input  ready
    );
    modport sink (
        input  valid, event_kind, scroll_delta, tap_zone, event_time, last_event,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/tgr_regs.sv -----
// APB configuration registers of the gesture recognizer.
// Depends on tgr_pkg.
`default_nettype none

module tgr_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tgr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tgr_pkg::DATA_W-1:0]   pwdata,
    output logic      [tgr_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output tgr_pkg::cfg_t                     cfg
);

    tgr_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_x            <= tgr_pkg::RST_RANGE_X;
            cfg_reg.range_y            <= tgr_pkg::RST_RANGE_Y;
            cfg_reg.tap_motion_limit   <= tgr_pkg::RST_TAP_MOTION;
            cfg_reg.tap_duration_limit <= tgr_pkg::RST_TAP_DURATION;
            cfg_reg.scroll_pitch       <= tgr_pkg::RST_SCROLL_PITCH;
            cfg_reg.edge_percent       <= tgr_pkg::RST_EDGE_PERCENT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                tgr_pkg::REG_RANGE_X:      cfg_reg.range_x            <= pwdata[15:0];
                tgr_pkg::REG_RANGE_Y:      cfg_reg.range_y            <= pwdata[15:0];
                tgr_pkg::REG_TAP_MOTION:   cfg_reg.tap_motion_limit   <= pwdata[15:0];
                tgr_pkg::REG_TAP_DURATION: cfg_reg.tap_duration_limit <= pwdata;
                tgr_pkg::REG_SCROLL_PITCH: cfg_reg.scroll_pitch       <= pwdata[15:0];
                tgr_pkg::REG_EDGE_PERCENT: cfg_reg.edge_percent       <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            tgr_pkg::REG_RANGE_X:      prdata = 32'(cfg_reg.range_x);
            tgr_pkg::REG_RANGE_Y:      prdata = 32'(cfg_reg.range_y);
            tgr_pkg::REG_TAP_MOTION:   prdata = 32'(cfg_reg.tap_motion_limit);
            tgr_pkg::REG_TAP_DURATION: prdata = cfg_reg.tap_duration_limit;
            tgr_pkg::REG_SCROLL_PITCH: prdata = 32'(cfg_reg.scroll_pitch);
            tgr_pkg::REG_EDGE_PERCENT: prdata = 32'(cfg_reg.edge_percent);
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tgr_ctrl.sv -----
// Sequencer of the gesture recognizer: steps one sample through click,
// touch routing, scroll ticks, tap check and the final beat. Depends on tgr_pkg.
`default_nettype none

module tgr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  tgr_pkg::stat_t      stat,
    output tgr_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLICK = 4'd1;
    localparam logic [3:0] S_ROUTE = 4'd2;
    localparam logic [3:0] S_TICK  = 4'd3;
    localparam logic [3:0] S_END_A = 4'd4;
    localparam logic [3:0] S_END_B = 4'd5;
    localparam logic [3:0] S_TAP   = 4'd6;
    localparam logic [3:0] S_FLUSH = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ev_sel = tgr_pkg::EV_CLICK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLICK;
                end
            end
            S_CLICK:
            begin
                if (!stat.btn_rise)
                begin
                    cmd.btn_upd = 1'b1;
                    state_next  = S_ROUTE;
                end
                else if (stat.emit_ok)
                begin
                    cmd.btn_upd = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.ev_sel  = tgr_pkg::EV_CLICK;
                    state_next  = S_ROUTE;
                end
            end
            S_ROUTE:
            begin
                if (stat.s_valid && stat.s_finger)
                begin
                    if (!stat.touching)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.move   = 1'b1;
                        state_next = stat.dy_zero ? S_FLUSH : S_TICK;
                    end
                end
                else
                begin
                    state_next = stat.touching ? S_END_A : S_FLUSH;
                end
            end
            S_TICK:
            begin
                if (stat.tick_up || stat.tick_dn)
                begin
                    if (stat.emit_ok)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.tick   = 1'b1;
                        cmd.ev_sel = stat.tick_up ? tgr_pkg::EV_UP : tgr_pkg::EV_DOWN;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_END_A:
            begin
                cmd.end_a  = 1'b1;
                state_next = S_END_B;
            end
            S_END_B:
            begin
                cmd.end_b  = 1'b1;
                state_next = S_TAP;
            end
            S_TAP:
            begin
                if (!stat.tap_ok)
                begin
                    state_next = S_FLUSH;
                end
                else if (stat.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ev_sel = tgr_pkg::EV_TAP;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.emit_ok)
        else $error("emit issued with no room for the beat");

    a_flush_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> stat.out_free)
        else $error("flush issued while output register is held");

    a_tick_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK) |-> ($past(state_reg) == S_ROUTE || $past(state_reg) == S_TICK))
        else $error("tick loop entered without a move");

endmodule

`default_nettype wire

// ----- rtl/tgr_dp.sv -----
// Datapath of the gesture recognizer: sample latch, touch state, scroll
// accumulator, tap zone arithmetic and the event staging and output
// registers. Depends on tgr_pkg.
`default_nettype none

module tgr_dp #(
    parameter int MAX_TICKS  = 16,
    parameter int COORD_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  tgr_pkg::cfg_t          cfg,
    input  tgr_pkg::cmd_t          cmd,
    output tgr_pkg::stat_t         stat,
    input  wire logic              in_sample_valid,
    input  wire logic              in_finger_down,
    input  wire logic [15:0]       in_pos_x,
    input  wire logic [15:0]       in_pos_y,
    input  wire logic [31:0]       in_time_ms,
    input  wire logic              in_button_down,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             event_kind,
    output logic signed [1:0]      scroll_delta,
    output logic [1:0]             tap_zone,
    output logic [31:0]            event_time,
    output logic                   last_event
);

    localparam int TW = $clog2(MAX_TICKS + 1);
    localparam logic [TW-1:0] TICK_CAP = TW'(MAX_TICKS);

    logic                         s_valid_reg;
    logic                         s_finger_reg;
    logic [COORD_BITS-1:0]        s_x_reg;
    logic [COORD_BITS-1:0]        s_y_reg;
    logic [31:0]                  s_time_reg;
    logic                         s_btn_reg;

    logic                         touching_reg;
    logic                         button_level_reg;
    logic [COORD_BITS-1:0]        origin_x_reg;
    logic [COORD_BITS-1:0]        origin_y_reg;
    logic [COORD_BITS-1:0]        recent_x_reg;
    logic [COORD_BITS-1:0]        recent_y_reg;
    logic [31:0]                  begin_time_reg;
    logic signed [31:0]           acc_reg;
    logic signed [31:0]           acc_next;
    logic [TW-1:0]                ticks_reg;

    logic                         tap_ok_reg;
    logic [tgr_pkg::PROD_W-1:0]   prod_x_reg;
    logic [tgr_pkg::PROD_W-1:0]   prod_y_reg;
    logic [15:0]                  left_reg;
    logic [15:0]                  top_reg;

    logic                         pend_valid_reg;
    logic [1:0]                   pend_kind_reg;
    logic signed [1:0]            pend_delta_reg;
    logic [1:0]                   pend_zone_reg;

    logic                         out_valid_reg;
    logic [1:0]                   out_kind_reg;
    logic signed [1:0]            out_delta_reg;
    logic [1:0]                   out_zone_reg;
    logic [31:0]                  out_time_reg;
    logic                         out_last_reg;

    logic [15:0]                  pitch_eff;
    logic signed [31:0]           pitch_s;
    logic signed [16:0]           dy_s;
    logic signed [32:0]           sum_s;
    logic signed [31:0]           sum_sat;
    logic                         tick_room;
    logic [31:0]                  dur;
    logic [COORD_BITS-1:0]        drift_x;
    logic [COORD_BITS-1:0]        drift_y;
    logic [tgr_pkg::PCT_W-1:0]    pct;
    logic [15:0]                  ox16;
    logic [15:0]                  oy16;
    logic [15:0]                  bottom;
    logic [15:0]                  right;
    logic [1:0]                   zone;
    logic [1:0]                   ev_kind;
    logic signed [1:0]            ev_delta;
    logic [1:0]                   ev_zone;
    logic                         out_free;
    logic                         push;

    assign pitch_eff = (cfg.scroll_pitch == 16'd0) ? 16'd1 : cfg.scroll_pitch;
    assign pitch_s   = $signed(32'(pitch_eff));
    assign dy_s      = $signed(17'(s_y_reg)) - $signed(17'(recent_y_reg));
    assign sum_s     = 33'(acc_reg) + 33'(dy_s);
    assign tick_room = ticks_reg < TICK_CAP;

    always_comb
    begin
        if (sum_s[32] != sum_s[31])
        begin
            sum_sat = sum_s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sum_sat = sum_s[31:0];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.start)
        begin
            acc_next = '0;
        end
        else if (cmd.move && !stat.dy_zero)
        begin
            acc_next = sum_sat;
        end
        else if (cmd.emit && cmd.tick)
        begin
            acc_next = (cmd.ev_sel == tgr_pkg::EV_UP) ? acc_reg - pitch_s : acc_reg + pitch_s;
        end
    end

    assign dur     = s_time_reg - begin_time_reg;
    assign drift_x = (recent_x_reg > origin_x_reg) ? recent_x_reg - origin_x_reg
                                                   : origin_x_reg - recent_x_reg;
    assign drift_y = (recent_y_reg > origin_y_reg) ? recent_y_reg - origin_y_reg
                                                   : origin_y_reg - recent_y_reg;
    assign pct     = (cfg.edge_percent > tgr_pkg::PCT_MAX) ? tgr_pkg::PCT_MAX
                                                           : cfg.edge_percent;

    assign ox16   = 16'(origin_x_reg);
    assign oy16   = 16'(origin_y_reg);
    assign bottom = cfg.range_y - top_reg;
    assign right  = cfg.range_x - left_reg;

    always_comb
    begin
        if (oy16 <= top_reg)
        begin
            zone = tgr_pkg::ZONE_MENU;
        end
        else if (oy16 >= bottom)
        begin
            zone = tgr_pkg::ZONE_PLAY;
        end
        else if (ox16 <= left_reg)
        begin
            zone = tgr_pkg::ZONE_PREV;
        end
        else if (ox16 >= right)
        begin
            zone = tgr_pkg::ZONE_NEXT;
        end
        else
        begin
            zone = tgr_pkg::ZONE_MENU;
        end
    end

    always_comb
    begin
        case (cmd.ev_sel)
            tgr_pkg::EV_UP:
            begin
                ev_kind  = tgr_pkg::KIND_SCROLL;
                ev_delta = tgr_pkg::DELTA_UP;
                ev_zone  = tgr_pkg::ZONE_MENU;
            end
            tgr_pkg::EV_DOWN:
            begin
                ev_kind  = tgr_pkg::KIND_SCROLL;
                ev_delta = tgr_pkg::DELTA_DOWN;
                ev_zone  = tgr_pkg::ZONE_MENU;
            end
            tgr_pkg::EV_TAP:
            begin
                ev_kind  = tgr_pkg::KIND_TAP;
                ev_delta = tgr_pkg::DELTA_NONE;
                ev_zone  = zone;
            end
            default:
            begin
                ev_kind  = tgr_pkg::KIND_CLICK;
                ev_delta = tgr_pkg::DELTA_NONE;
                ev_zone  = tgr_pkg::ZONE_MENU;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;
    assign push     = (cmd.emit && pend_valid_reg) || cmd.flush;

    always_comb
    begin
        stat            = '0;
        stat.s_valid    = s_valid_reg;
        stat.s_finger   = s_finger_reg;
        stat.touching   = touching_reg;
        stat.btn_rise   = s_btn_reg && !button_level_reg;
        stat.dy_zero    = (s_y_reg == recent_y_reg);
        stat.tick_up    = tick_room && (acc_reg >= pitch_s);
        stat.tick_dn    = tick_room && (acc_reg <= -pitch_s);
        stat.tap_ok     = tap_ok_reg;
        stat.emit_ok    = !pend_valid_reg || out_free;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_valid_reg  <= in_sample_valid;
            s_finger_reg <= in_finger_down;
            s_x_reg      <= in_pos_x[COORD_BITS-1:0];
            s_y_reg      <= in_pos_y[COORD_BITS-1:0];
            s_time_reg   <= in_time_ms;
            s_btn_reg    <= in_button_down;
        end
        if (cmd.end_a)
        begin
            prod_x_reg <= tgr_pkg::PROD_W'(cfg.range_x) * tgr_pkg::PROD_W'(pct);
            prod_y_reg <= tgr_pkg::PROD_W'(cfg.range_y) * tgr_pkg::PROD_W'(pct);
        end
        if (cmd.end_b)
        begin
            left_reg <= 16'((tgr_pkg::QPROD_W'(prod_x_reg) * tgr_pkg::QPROD_W'(tgr_pkg::RECIP_100))
                            >> tgr_pkg::RECIP_SHIFT);
            top_reg  <= 16'((tgr_pkg::QPROD_W'(prod_y_reg) * tgr_pkg::QPROD_W'(tgr_pkg::RECIP_100))
                            >> tgr_pkg::RECIP_SHIFT);
        end
        if (cmd.emit)
        begin
            pend_kind_reg  <= ev_kind;
            pend_delta_reg <= ev_delta;
            pend_zone_reg  <= ev_zone;
        end
        if (push)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_delta_reg <= pend_delta_reg;
            out_zone_reg  <= pend_zone_reg;
            out_time_reg  <= s_time_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touching_reg     <= 1'b0;
            button_level_reg <= 1'b0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            recent_x_reg     <= '0;
            recent_y_reg     <= '0;
            begin_time_reg   <= '0;
            acc_reg          <= '0;
            ticks_reg        <= '0;
            tap_ok_reg       <= 1'b0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.btn_upd)
            begin
                button_level_reg <= s_btn_reg;
            end
            if (cmd.start)
            begin
                touching_reg   <= 1'b1;
                origin_x_reg   <= s_x_reg;
                origin_y_reg   <= s_y_reg;
                recent_x_reg   <= s_x_reg;
                recent_y_reg   <= s_y_reg;
                begin_time_reg <= s_time_reg;
            end
            if (cmd.move)
            begin
                recent_x_reg <= s_x_reg;
                recent_y_reg <= s_y_reg;
                ticks_reg    <= '0;
            end
            else if (cmd.emit && cmd.tick)
            begin
                ticks_reg <= ticks_reg + TW'(1);
            end
            if (cmd.end_a)
            begin
                touching_reg <= 1'b0;
                tap_ok_reg   <= (dur <= cfg.tap_duration_limit)
                             && (16'(drift_x) <= cfg.tap_motion_limit)
                             && (16'(drift_y) <= cfg.tap_motion_limit);
            end
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = out_kind_reg;
    assign scroll_delta = out_delta_reg;
    assign tap_zone     = out_zone_reg;
    assign event_time   = out_time_reg;
    assign last_event   = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("output register overwritten while held");

    a_tick_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ticks_reg <= TICK_CAP)
        else $error("tick count beyond cap");

    a_scroll_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == tgr_pkg::KIND_SCROLL)
            |-> (out_delta_reg == tgr_pkg::DELTA_UP || out_delta_reg == tgr_pkg::DELTA_DOWN))
        else $error("scroll beat without direction");

endmodule

`default_nettype wire

// ----- rtl/touchpad_gesture_recognizer.sv -----
// Touchpad gesture recognizer: one poll sample per beat in, click, scroll and tap beats out.
// Each sample steps through click check, touch routing, the scroll tick loop and, on a touch
// release, the tap check before its final beat, if any; earlier beats leave ahead of it.
// A new sample is taken only once the previous one is through and the sequencer is idle; the
// scroll loop emits one tick per cycle while the event stage has room. Output stalls hold it.
// Reset: rst_n clears touch state, scroll accumulator and button level and loads defaults.
`default_nettype none

module touchpad_gesture_recognizer #(
    parameter int MAX_TICKS  = 16,
    parameter int COORD_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tgr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tgr_pkg::DATA_W-1:0]   pwdata,
    output logic      [tgr_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    tgr_sample_if.sink                        sample,
    tgr_event_if.source                       evt
);

    tgr_pkg::cfg_t  cfg;
    tgr_pkg::cmd_t  cmd;
    tgr_pkg::stat_t stat;
    logic           in_ready;

    assign sample.ready = in_ready;

    tgr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tgr_dp #(
        .MAX_TICKS  (MAX_TICKS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .in_sample_valid (sample.sample_valid),
        .in_finger_down  (sample.finger_down),
        .in_pos_x        (sample.pos_x),
        .in_pos_y        (sample.pos_y),
        .in_time_ms      (sample.time_ms),
        .in_button_down  (sample.button_down),
        .out_valid       (evt.valid),
        .out_ready       (evt.ready),
        .event_kind      (evt.event_kind),
        .scroll_delta    (evt.scroll_delta),
        .tap_zone        (evt.tap_zone),
        .event_time      (evt.event_time),
        .last_event      (evt.last_event)
    );

endmodule

`default_nettype wire
